### hdl/uart_8n1_transceiver_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 8N1 UART transceiver core.
// ---------------------------------------------------------------------------
`ifndef UART_8N1_TRANSCEIVER_CORE_MACROS_SVH
`define UART_8N1_TRANSCEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define UART_AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define UART_AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/uart_pkg.sv
// ---------------------------------------------------------------------------
// uart_pkg
// Types and constants for the 8N1 UART transceiver core.
// ---------------------------------------------------------------------------
package uart_pkg;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_BIT_PERIOD = 1'b0,
        CFG_RX_TIMEOUT = 1'b1
    } cfg_index_t;

    // Receive phases
    typedef enum logic [2:0] {
        RX_IDLE  = 3'd0,
        RX_START = 3'd1,
        RX_HALF  = 3'd2,
        RX_DATA  = 3'd3,
        RX_STOP  = 3'd4
    } rx_phase_t;

    localparam logic [15:0] BIT_PERIOD_RESET = 16'd417;
    localparam logic [15:0] MIN_PERIOD       = 16'd4;
    localparam logic [3:0]  TX_STOP_INDEX    = 4'd9;
    localparam logic [2:0]  RX_LAST_BIT      = 3'd7;
    localparam logic [7:0]  MSB_MASK         = 8'h80;
    localparam logic [7:0]  LSB_MASK         = 8'h01;

    // One result item
    typedef struct packed {
        logic       rx_timed_out;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       tx_busy;
        logic       tx_line;
    } result_t;

endpackage

### hdl/uart_8n1_transceiver_core.sv
// ---------------------------------------------------------------------------
// uart_8n1_transceiver_core
// Result: the result item for an input item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle; a single result register parts the two sides and
// input is taken whenever that register is empty or being drained.
// Reset: rst_n clears all UART state; line idles high, bit_period 417, rx_timeout 0.
// ---------------------------------------------------------------------------
`include "uart_8n1_transceiver_core_macros.svh"

module uart_8n1_transceiver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wen,
    input  uart_pkg::cfg_index_t                cfg_index,
    input  logic [uart_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items: [0] rx_line, [1] tx_start, [9:2] tx_data, [10] rx_arm, rest zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [uart_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result items: [0] tx_line, [1] tx_busy, [9:2] rx_data, [10] rx_valid,
    //               [11] rx_timed_out, rest zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [uart_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import uart_pkg::*;

    // Configuration registers
    logic [15:0] bit_period_reg;
    logic [31:0] rx_timeout_reg;

    // Transmit state
    logic [7:0]  tx_shift_reg, tx_shift_next;
    logic [3:0]  tx_bit_index_reg, tx_bit_index_next;
    logic [15:0] tx_timer_reg, tx_timer_next;
    logic        tx_active_reg, tx_active_next;

    // Receive state
    rx_phase_t   rx_phase_reg, rx_phase_next;
    logic [15:0] rx_timer_reg, rx_timer_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    logic [2:0]  rx_bit_index_reg, rx_bit_index_next;
    logic [31:0] rx_countdown_reg, rx_countdown_next;

    // Result register
    logic        m_tvalid_reg;
    result_t     result_reg, result_next;

    // Unpacked input item
    logic        in_rx_line;
    logic        in_tx_start;
    logic [7:0]  in_tx_data;
    logic        in_rx_arm;
    logic        accept;

    assign in_rx_line  = s_tdata[0];
    assign in_tx_start = s_tdata[1];
    assign in_tx_data  = s_tdata[9:2];
    assign in_rx_arm   = s_tdata[10];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
            rx_timeout_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_BIT_PERIOD: bit_period_reg <= cfg_data[15:0];
                CFG_RX_TIMEOUT: rx_timeout_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // One tick of transmitter and receiver
    always_comb
    begin
        logic [15:0] period;
        logic [15:0] half_period;
        logic [16:0] tx_timer_inc;
        logic [16:0] rx_timer_inc;
        logic [31:0] countdown;
        logic        cd_expire;
        logic        tx_out;
        logic        rx_valid;
        logic [7:0]  rx_got;
        logic        timed_out;

        period       = (bit_period_reg < MIN_PERIOD) ? MIN_PERIOD : bit_period_reg;
        half_period  = period >> 1;
        tx_timer_inc = {1'b0, tx_timer_reg} + 17'd1;
        rx_timer_inc = {1'b0, rx_timer_reg} + 17'd1;

        tx_shift_next     = tx_shift_reg;
        tx_bit_index_next = tx_bit_index_reg;
        tx_timer_next     = tx_timer_reg;
        tx_active_next    = tx_active_reg;
        rx_phase_next     = rx_phase_reg;
        rx_timer_next     = rx_timer_reg;
        rx_shift_next     = rx_shift_reg;
        rx_bit_index_next = rx_bit_index_reg;
        tx_out            = 1'b1;
        rx_valid          = 1'b0;
        rx_got            = '0;
        timed_out         = 1'b0;

        // transmitter: advance the current bit
        if (tx_active_reg)
        begin
            if (tx_timer_inc >= {1'b0, period})
            begin
                tx_timer_next = '0;
                if (tx_bit_index_reg inside {[4'd1:4'd8]})
                    tx_shift_next = tx_shift_reg >> 1;
                if (tx_bit_index_reg == TX_STOP_INDEX)
                begin
                    tx_active_next    = 1'b0;
                    tx_bit_index_next = '0;
                end
                else
                    tx_bit_index_next = tx_bit_index_reg + 4'd1;
            end
            else
                tx_timer_next = tx_timer_inc[15:0];
        end
        // new frame may start on the tick the last one ends
        if (!tx_active_next && in_tx_start)
        begin
            tx_active_next    = 1'b1;
            tx_shift_next     = in_tx_data;
            tx_bit_index_next = '0;
            tx_timer_next     = '0;
        end
        if (tx_active_next)
        begin
            if (tx_bit_index_next == 4'd0)
                tx_out = 1'b0;
            else if (tx_bit_index_next <= 4'd8)
                tx_out = |(tx_shift_next & LSB_MASK);
            else
                tx_out = 1'b1;
        end

        // receive countdown: arm reloads before the tick is processed
        countdown = in_rx_arm ? rx_timeout_reg : rx_countdown_reg;
        cd_expire = (countdown == 32'd1);
        rx_countdown_next = countdown;

        case (rx_phase_reg)
            RX_IDLE:
            begin
                if (in_rx_line)
                    rx_phase_next = RX_START;
                else if (countdown != '0)
                begin
                    rx_countdown_next = countdown - 32'd1;
                    timed_out         = cd_expire;
                end
            end
            RX_START:
            begin
                if (!in_rx_line)
                begin
                    rx_phase_next = RX_HALF;
                    rx_timer_next = '0;
                end
                else if (countdown != '0)
                begin
                    rx_countdown_next = countdown - 32'd1;
                    if (cd_expire)
                    begin
                        timed_out     = 1'b1;
                        rx_phase_next = RX_IDLE;
                    end
                end
            end
            RX_HALF:
            begin
                if (rx_timer_inc >= {1'b0, half_period})
                begin
                    rx_phase_next     = RX_DATA;
                    rx_timer_next     = '0;
                    rx_bit_index_next = '0;
                end
                else
                    rx_timer_next = rx_timer_inc[15:0];
            end
            RX_DATA:
            begin
                if (rx_timer_inc >= {1'b0, period})
                begin
                    rx_timer_next = '0;
                    rx_shift_next = (rx_shift_reg >> 1) | (in_rx_line ? MSB_MASK : 8'h00);
                    if (rx_bit_index_reg == RX_LAST_BIT)
                    begin
                        rx_bit_index_next = '0;
                        rx_phase_next     = RX_STOP;
                    end
                    else
                        rx_bit_index_next = rx_bit_index_reg + 3'd1;
                end
                else
                    rx_timer_next = rx_timer_inc[15:0];
            end
            RX_STOP:
            begin
                if (in_rx_line)
                begin
                    rx_valid      = 1'b1;
                    rx_got        = rx_shift_reg;
                    rx_phase_next = RX_START;
                end
            end
            default:
                rx_phase_next = RX_IDLE;
        endcase

        result_next.tx_line      = tx_out;
        result_next.tx_busy      = tx_active_next;
        result_next.rx_data      = rx_got;
        result_next.rx_valid     = rx_valid;
        result_next.rx_timed_out = timed_out;
    end

    // State update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg     <= '0;
            tx_bit_index_reg <= '0;
            tx_timer_reg     <= '0;
            tx_active_reg    <= 1'b0;
            rx_phase_reg     <= RX_IDLE;
            rx_timer_reg     <= '0;
            rx_shift_reg     <= '0;
            rx_bit_index_reg <= '0;
            rx_countdown_reg <= '0;
        end
        else if (accept)
        begin
            tx_shift_reg     <= tx_shift_next;
            tx_bit_index_reg <= tx_bit_index_next;
            tx_timer_reg     <= tx_timer_next;
            tx_active_reg    <= tx_active_next;
            rx_phase_reg     <= rx_phase_next;
            rx_timer_reg     <= rx_timer_next;
            rx_shift_reg     <= rx_shift_next;
            rx_bit_index_reg <= rx_bit_index_next;
            rx_countdown_reg <= rx_countdown_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    // Checks
    `UART_AST_NXT(a_accept_gives_result, clk, rst_n, accept, m_tvalid_reg,
        "accepted item produced no result")
    `UART_AST_IMP(a_rx_flags_exclusive, clk, rst_n, m_tvalid_reg,
        !(result_reg.rx_valid && result_reg.rx_timed_out), "byte and timeout in one item")
    `UART_AST_IMP(a_idle_line_high, clk, rst_n, m_tvalid_reg && !result_reg.tx_busy,
        result_reg.tx_line, "transmit line low while idle")
    `UART_AST_IMP(a_rx_data_zero, clk, rst_n, m_tvalid_reg && !result_reg.rx_valid,
        result_reg.rx_data == 8'h00, "rx_data nonzero without rx_valid")
    `UART_AST_IMP(a_tx_index_range, clk, rst_n, 1'b1,
        tx_bit_index_reg <= TX_STOP_INDEX, "transmit bit index out of range")

endmodule

### sim/tb_uart_8n1_transceiver_core.sv
// ---------------------------------------------------------------------------
// tb_uart_8n1_transceiver_core
// Self-checking bench for the 8N1 UART core. Every item is one clock tick of
// the serial receive line plus a transmit request; a cycle-accurate UART
// model predicts each result item and a scoreboard checks all fields. The
// receive line carries generated 8N1 frames, clean and damaged, at several
// bit periods and timeout settings, with random idling on both streams.
// ---------------------------------------------------------------------------
module tb_uart_8n1_transceiver_core;
    import uart_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          HOLD_LEN    = 300;

    // One input item, lowest bit first: rx_line, tx_start, tx_data, rx_arm
    typedef struct packed {
        logic       rx_arm;
        logic [7:0] tx_data;
        logic       tx_start;
        logic       rx_line;
    } tick_t;

    // UART model and result checker
    class uart_scoreboard;
        logic [15:0] bit_period;
        logic [31:0] rx_timeout;
        logic [7:0]  tx_shift;
        logic [3:0]  tx_bit_idx;
        logic [15:0] tx_timer;
        logic        tx_active;
        rx_phase_t   rx_phase;
        logic [15:0] rx_timer;
        logic [7:0]  rx_shift;
        logic [3:0]  rx_bit_idx;
        logic [31:0] rx_countdown;
        result_t     expected_results[$];
        int          errors;

        function new();
            bit_period   = BIT_PERIOD_RESET;
            rx_timeout   = '0;
            tx_shift     = '0;
            tx_bit_idx   = '0;
            tx_timer     = '0;
            tx_active    = 1'b0;
            rx_phase     = RX_IDLE;
            rx_timer     = '0;
            rx_shift     = '0;
            rx_bit_idx   = '0;
            rx_countdown = '0;
            errors       = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] value);
            if (idx == CFG_BIT_PERIOD)
                bit_period = value[15:0];
            else
                rx_timeout = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // armed countdown; true on the tick it runs out
        function bit countdown_expired();
            if (rx_countdown == '0)
                return 1'b0;
            rx_countdown--;
            return rx_countdown == '0;
        endfunction

        function result_t uart_tick(tick_t t);
            result_t     r;
            logic [15:0] period;
            r         = '0;
            r.tx_line = 1'b1;
            period    = (bit_period < MIN_PERIOD) ? MIN_PERIOD : bit_period;

            // transmitter: advance the running frame, then take a new request
            if (tx_active)
            begin
                tx_timer++;
                if (tx_timer >= period)
                begin
                    tx_timer = '0;
                    if (tx_bit_idx >= 1 && tx_bit_idx <= 8)
                        tx_shift = tx_shift >> 1;
                    tx_bit_idx++;
                    if (tx_bit_idx > TX_STOP_INDEX)
                    begin
                        tx_active  = 1'b0;
                        tx_bit_idx = '0;
                    end
                end
            end
            if (!tx_active && t.tx_start)
            begin
                tx_active  = 1'b1;
                tx_shift   = t.tx_data;
                tx_bit_idx = '0;
                tx_timer   = '0;
            end
            if (tx_active)
            begin
                if (tx_bit_idx == 0)
                    r.tx_line = 1'b0;
                else if (tx_bit_idx < TX_STOP_INDEX)
                    r.tx_line = |(tx_shift & LSB_MASK);
            end
            r.tx_busy = tx_active;

            // receiver
            if (t.rx_arm)
                rx_countdown = rx_timeout;
            case (rx_phase)
                RX_IDLE:
                begin
                    if (t.rx_line)
                        rx_phase = RX_START;
                    else if (countdown_expired())
                        r.rx_timed_out = 1'b1;
                end
                RX_START:
                begin
                    if (!t.rx_line)
                    begin
                        rx_phase = RX_HALF;
                        rx_timer = '0;
                    end
                    else if (countdown_expired())
                    begin
                        r.rx_timed_out = 1'b1;
                        rx_phase       = RX_IDLE;
                    end
                end
                RX_HALF:
                begin
                    rx_timer++;
                    if (rx_timer >= (period >> 1))
                    begin
                        rx_phase   = RX_DATA;
                        rx_timer   = '0;
                        rx_bit_idx = '0;
                    end
                end
                RX_DATA:
                begin
                    rx_timer++;
                    if (rx_timer >= period)
                    begin
                        rx_timer = '0;
                        rx_shift = (rx_shift >> 1) | (t.rx_line ? MSB_MASK : 8'h00);
                        rx_bit_idx++;
                        if (rx_bit_idx > RX_LAST_BIT)
                        begin
                            rx_bit_idx = '0;
                            rx_phase   = RX_STOP;
                        end
                    end
                end
                RX_STOP:
                begin
                    if (t.rx_line)
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_data  = rx_shift;
                        rx_phase   = RX_START;
                    end
                end
                default:
                    rx_phase = RX_IDLE;
            endcase
            return r;
        endfunction

        function void note_input(logic [IN_TDATA_W-1:0] d);
            expected_results.push_back(uart_tick(tick_t'(d[$bits(tick_t)-1:0])));
        endfunction

        task report(string field, int unsigned got, int unsigned want);
            errors++;
            if (errors <= 50)
                $display("MISMATCH %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d);
            result_t got;
            result_t want;
            if (expected_results.size() == 0)
            begin
                report("result with nothing pending", d, 0);
                return;
            end
            want = expected_results.pop_front();
            got  = result_t'(d[$bits(result_t)-1:0]);
            if (got.tx_line !== want.tx_line)
                report("tx_line", got.tx_line, want.tx_line);
            if (got.tx_busy !== want.tx_busy)
                report("tx_busy", got.tx_busy, want.tx_busy);
            if (got.rx_data !== want.rx_data)
                report("rx_data", got.rx_data, want.rx_data);
            if (got.rx_valid !== want.rx_valid)
                report("rx_valid", got.rx_valid, want.rx_valid);
            if (got.rx_timed_out !== want.rx_timed_out)
                report("rx_timed_out", got.rx_timed_out, want.rx_timed_out);
            if (d[OUT_TDATA_W-1:$bits(result_t)] !== '0)
                report("pad bits", d[OUT_TDATA_W-1:$bits(result_t)], 0);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    uart_scoreboard sb;
    tick_t          tick_q[$];
    int             sender_idle_pct;
    int             recv_stall_pct;
    bit             hold_req;

    uart_8n1_transceiver_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Handshake monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic void push_fields(logic line, logic start, logic [7:0] data, logic arm);
        tick_t t;
        t.rx_line  = line;
        t.tx_start = start;
        t.tx_data  = data;
        t.rx_arm   = arm;
        tick_q.push_back(t);
    endfunction

    // line level with random transmit requests and re-arms
    function automatic void push_tick(logic line);
        push_fields(line, $urandom_range(29) == 0, 8'($urandom_range(255)),
                    $urandom_range(39) == 0);
    endfunction

    // one 8N1 frame on the receive line; skewed frames get uneven bits
    function automatic void queue_frame(logic [7:0] b, int p, bit skewed);
        int len;
        len = p + (skewed ? int'($urandom_range(2)) - 1 : 0);
        repeat (len) push_tick(1'b0);
        for (int i = 0; i < 8; i++)
        begin
            len = p + (skewed ? int'($urandom_range(2)) - 1 : 0);
            repeat (len) push_tick(b[i]);
        end
        len = skewed ? int'($urandom_range(p)) : p;
        repeat (len) push_tick(1'b1);
    endfunction

    // mostly clean frames, the rest skewed frames, glitches, noise and flat stretches
    function automatic void build_traffic(int n, int p);
        int target;
        int r;
        target = tick_q.size() + n;
        while (tick_q.size() < target)
        begin
            r = $urandom_range(99);
            repeat ($urandom_range(2 * p)) push_tick(1'b1);
            if (r < 65)
                queue_frame(8'($urandom_range(255)), p, 1'b0);
            else if (r < 78)
                queue_frame(8'($urandom_range(255)), p, 1'b1);
            else if (r < 86)
                repeat ($urandom_range(1, 2)) push_tick(1'b0);
            else if (r < 93)
                repeat ($urandom_range(4, 4 * p)) push_tick(1'($urandom_range(1)));
            else
                repeat ($urandom_range(p, 8 * p)) push_tick(1'(r & 1));
        end
    endfunction

    task automatic send_ticks();
        tick_t t;
        while (tick_q.size() > 0)
        begin
            @(negedge clk);
            if ($urandom_range(99) < sender_idle_pct)
                s_tvalid <= 1'b0;
            else
            begin
                t = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_W'(t);
                do
                    @(posedge clk);
                while (!s_tready);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic run_traffic(int n, int p);
        build_traffic(n, p);
        send_ticks();
        drain();
    endtask

    // Main sequence
    initial
    begin
        sb              = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req        = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = CFG_BIT_PERIOD;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        rst_n           = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a few ticks at the reset settings
        repeat (3) push_tick(1'b1);
        send_ticks();
        drain();

        // directed: timeouts in both wait phases, busy request, byte extremes
        write_reg(CFG_BIT_PERIOD, 32'd4);
        write_reg(CFG_RX_TIMEOUT, 32'd3);
        push_fields(1'b0, 1'b0, 8'h00, 1'b1);
        push_fields(1'b0, 1'b0, 8'h00, 1'b0);
        push_fields(1'b0, 1'b0, 8'h00, 1'b0);
        push_fields(1'b1, 1'b1, 8'hFF, 1'b0);
        push_fields(1'b1, 1'b1, 8'h00, 1'b1);
        push_fields(1'b1, 1'b0, 8'h00, 1'b0);
        push_fields(1'b1, 1'b0, 8'h00, 1'b0);
        push_fields(1'b1, 1'b0, 8'h00, 1'b0);
        push_fields(1'b1, 1'b0, 8'h00, 1'b0);
        queue_frame(8'h00, 4, 1'b0);
        queue_frame(8'hFF, 4, 1'b0);
        push_fields(1'b1, 1'b1, 8'h00, 1'b0);
        run_traffic(180, 4);

        // sender mostly idle, longest timeout
        sender_idle_pct = 86;
        write_reg(CFG_BIT_PERIOD, 32'd7);
        write_reg(CFG_RX_TIMEOUT, 32'hFFFF_FFFF);
        run_traffic(350, 7);

        // receiver mostly stalling; period below the floor acts as 4
        sender_idle_pct = 0;
        recv_stall_pct  = 86;
        write_reg(CFG_BIT_PERIOD, 32'd2);
        write_reg(CFG_RX_TIMEOUT, 32'd40);
        run_traffic(350, 4);

        // both idling; long result hold-off, then a full pause of the sender
        sender_idle_pct = 21;
        recv_stall_pct  = 21;
        write_reg(CFG_BIT_PERIOD, 32'd11);
        write_reg(CFG_RX_TIMEOUT, 32'd0);
        hold_req = 1'b1;
        run_traffic(150, 11);
        run_traffic(150, 11);

        // longest period, shortest nonzero timeout
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        write_reg(CFG_BIT_PERIOD, 32'd65535);
        write_reg(CFG_RX_TIMEOUT, 32'd1);
        push_fields(1'b0, 1'b1, 8'h5A, 1'b1);
        repeat (30)
            push_fields(1'($urandom_range(1)), 1'($urandom_range(1)),
                        8'($urandom_range(255)), $urandom_range(3) == 0);
        send_ticks();
        drain();

        write_reg(CFG_BIT_PERIOD, 32'd0);
        write_reg(CFG_RX_TIMEOUT, 32'd17);
        run_traffic(150, 4);
        write_reg(CFG_BIT_PERIOD, 32'd5);
        run_traffic(100, 5);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
